[design/serial_commanded_wave_generator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the serial commanded wave generator
// Clocked assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMANDED_WAVE_GENERATOR_ASSERT_SVH
`define SERIAL_COMMANDED_WAVE_GENERATOR_ASSERT_SVH

// Checked only while out of reset.
`define SCWG_CHECK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SCWG_CHECK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/scwg_pkg.sv]
// ----------------------------------------------------------------------------
// scwg_pkg
// Shared constants, codes and types of the serial commanded wave generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scwg_pkg;

  localparam int NUM_WAVES   = 5;
  localparam int FRAME_BYTES = 9;
  localparam int WAVE_LIMIT  = (NUM_WAVES < 5) ? NUM_WAVES : 5;

  // Frame characters
  localparam logic [7:0] CH_START = 8'h40;  // '@'
  localparam logic [7:0] CH_END   = 8'h3B;  // ';'
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_9     = 8'h39;  // '9'

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_SAMPLE    = 2'd0;
  localparam logic [1:0] KIND_FRAME_OK  = 2'd1;
  localparam logic [1:0] KIND_FRAME_BAD = 2'd2;

  // Wave codes
  localparam logic [7:0] WAVE_SQUARE = 8'd0;
  localparam logic [7:0] WAVE_STAIR  = 8'd1;
  localparam logic [7:0] WAVE_TRI    = 8'd2;
  localparam logic [7:0] WAVE_SINE   = 8'd3;
  localparam logic [7:0] WAVE_FULL   = 8'd4;
  localparam logic [7:0] WAVE_NONE   = 8'd5;

  // Period arithmetic
  localparam int         DIVIDEND_W = 10;
  localparam int         DIVISOR_W  = 8;
  localparam int         DIV_STEPS  = DIVIDEND_W;
  localparam int         DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam logic [DIVIDEND_W-1:0] PERIOD_NUM = 10'd1000;
  localparam logic [7:0] FREQ_MIN   = 8'd4;
  localparam logic [7:0] PERIOD_SAT = 8'd255;
  localparam logic [7:0] LEVEL_FULL = 8'd255;
  // x/5 as (x*205)>>10, exact for x below 1024
  localparam logic [7:0] STAIR_RECIP = 8'd205;
  localparam int         STAIR_SHIFT = 10;
  localparam logic [8:0] RAMP_STEP  = 9'd10;
  localparam logic [8:0] TRI_TOP    = 9'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_PDIV
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic       last;   // this byte closes the frame
    logic       ok;     // start and end characters match
    logic [7:0] wave;
    logic [7:0] amp;
    logic [7:0] freq;
  } frame_evt_t;

endpackage

[design/scwg_div.sv]
// ----------------------------------------------------------------------------
// scwg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scwg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  scwg_pkg::div_req_t req,
  output scwg_pkg::div_rsp_t rsp
);
  import scwg_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;

  logic [DIVISOR_W:0] rem_sh;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIVIDEND_W-1]};
    fits     = rem_sh >= {1'b0, dvs_r};
    diff     = rem_sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[design/scwg_frame.sv]
// ----------------------------------------------------------------------------
// scwg_frame
// Command frame buffer and field decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scwg_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_we,
  input  logic [7:0]           rx_byte,
  output scwg_pkg::frame_evt_t evt
);
  import scwg_pkg::*;

  localparam int STORE_DEPTH = FRAME_BYTES - 1;

  logic [3:0] pos_r, pos_nxt;
  logic [7:0] store_r [STORE_DEPTH];

  // Leading decimal digits of three bytes, low eight bits kept.
  function automatic logic [7:0] parse3(input logic [2:0][7:0] p);
    logic [9:0] v;
    logic       go;
    v  = '0;
    go = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (go && p[k] >= CH_0 && p[k] <= CH_9) begin
        v = 10'(v * 10'd10) + 10'(p[k][3:0]);
      end else begin
        go = 1'b0;
      end
    end
    return v[7:0];
  endfunction

  always_comb begin
    evt.last = pos_r == 4'(STORE_DEPTH);
    evt.ok   = (store_r[0] == CH_START) && (rx_byte == CH_END);
    evt.wave = store_r[1] - CH_0;
    evt.amp  = parse3({store_r[4], store_r[3], store_r[2]});
    evt.freq = parse3({store_r[7], store_r[6], store_r[5]});
    pos_nxt  = pos_r;
    if (byte_we) begin
      pos_nxt = evt.last ? 4'd0 : pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
    if (byte_we && !evt.last) begin
      store_r[pos_r[2:0]] <= rx_byte;
    end
  end

endmodule

[design/serial_commanded_wave_generator.sv]
// ----------------------------------------------------------------------------
// serial_commanded_wave_generator
// Frame-commanded DAC wave generator with an iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_opcode / in_rx_byte) carries either
//   a received serial byte or a sample tick. Nine bytes form a command frame
//   '@', wave digit, three amplitude chars, three frequency chars, ';'.
//   Output channel (out_valid / out_stall / out_kind / out_level) returns one
//   transfer for a DAC sample, a frame accept or a frame reject; bytes inside
//   a frame and ticks with no wave selected give no transfer.
//   One item is in work at a time; in_stall is high from the transfer until
//   the item finishes. The item is captured in the input register, then
//     a byte is decoded in ST_EXEC (frame reject, or accept with freq below 4),
//     an accepted frame waits in ST_PDIV for 1000/freq on the divider,
//     a tick passes ST_EXEC and ST_TICK; staircase steps k*A/5 use a
//   reciprocal multiply. The divider retires one quotient bit per cycle and
//   is the slowest path. A result waits in the output register while out_stall
//   is high; the next input transfer is taken once that register empties or
//   drains in the same cycle.
//   Synchronous reset (rst_n low) clears the frame position, drops any
//   pending frame, selects no wave and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_commanded_wave_generator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_level
);
  import scwg_pkg::*;

  state_t state_r, state_nxt;

  // Captured item
  logic       op_r, op_nxt;
  logic [7:0] byte_r, byte_nxt;

  // Pending and active settings
  logic       pend_flag_r, pend_flag_nxt;
  logic [7:0] pend_wave_r, pend_wave_nxt;
  logic [7:0] pend_amp_r, pend_amp_nxt;
  logic [7:0] pend_per_r, pend_per_nxt;
  logic [7:0] act_wave_r, act_wave_nxt;
  logic [7:0] act_amp_r, act_amp_nxt;
  logic [7:0] act_per_r, act_per_nxt;

  // Wave position
  logic [2:0] seg_idx_r, seg_idx_nxt;
  logic [8:0] seg_ticks_r, seg_ticks_nxt;
  logic [8:0] ramp_r, ramp_nxt;
  logic       fall_r, fall_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic [7:0] out_level_r, out_level_nxt;

  // Submodule links
  logic       frame_we;
  frame_evt_t evt;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  // Wave step results (from the active settings)
  logic        at_start;
  logic        wave_ok;
  logic [9:0]  stair_prod;
  logic [17:0] stair_scaled;
  logic [7:0]  stair_lvl;
  logic [7:0]  direct_lvl;
  logic [2:0]  adv_idx;
  logic [8:0]  adv_ticks;
  logic [8:0]  adv_ramp;
  logic        adv_fall;
  logic        end_per;
  logic [8:0]  seg_len;
  logic [8:0]  tick_inc;
  logic [8:0]  sine_up;

  scwg_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_we (frame_we),
    .rx_byte (byte_r),
    .evt     (evt)
  );

  scwg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign at_start = (seg_idx_r == 3'd0) && (seg_ticks_r == 9'd0) &&
                    (ramp_r == 9'd0) && !fall_r;
  assign wave_ok  = act_wave_r < 8'(WAVE_LIMIT);
  assign tick_inc = seg_ticks_r + 9'd1;
  assign sine_up  = ramp_r + RAMP_STEP;

  // Staircase middle steps need k*A/5 with k = 4,3,2,1 for steps 1..4;
  // the divide by 5 is a multiply by 205 and a shift by 10.
  always_comb begin
    stair_prod = {2'b00, act_amp_r};
    unique case (seg_idx_r)
      3'd1:    stair_prod = {act_amp_r, 2'b00};
      3'd2:    stair_prod = {1'b0, act_amp_r, 1'b0} + {2'b00, act_amp_r};
      3'd3:    stair_prod = {1'b0, act_amp_r, 1'b0};
      default: stair_prod = {2'b00, act_amp_r};
    endcase
    stair_scaled = 18'(stair_prod) * 18'(STAIR_RECIP);
    stair_lvl    = stair_scaled[STAIR_SHIFT +: 8];
  end

  // One tick of the active wave: level and next position.
  always_comb begin
    direct_lvl = '0;
    adv_idx    = seg_idx_r;
    adv_ticks  = seg_ticks_r;
    adv_ramp   = ramp_r;
    adv_fall   = fall_r;
    end_per    = 1'b0;
    seg_len    = {1'b0, act_per_r};
    unique case (act_wave_r)
      WAVE_SQUARE: begin
        direct_lvl = (seg_idx_r == 3'd0) ? act_amp_r : 8'd0;
        seg_len    = (seg_idx_r == 3'd0) ? {act_per_r, 1'b0} : {2'b00, act_per_r[7:1]};
        if (seg_len == 9'd0) begin
          seg_len = 9'd1;
        end
        if (tick_inc >= seg_len) begin
          adv_ticks = '0;
          if (seg_idx_r >= 3'd1) begin
            end_per = 1'b1;
          end else begin
            adv_idx = seg_idx_r + 3'd1;
          end
        end else begin
          adv_ticks = tick_inc;
        end
      end
      WAVE_STAIR: begin
        if (seg_idx_r == 3'd0) begin
          direct_lvl = 8'd0;
        end else if (seg_idx_r >= 3'd5) begin
          direct_lvl = act_amp_r;
        end else begin
          direct_lvl = stair_lvl;
        end
        if (seg_len == 9'd0) begin
          seg_len = 9'd1;
        end
        if (tick_inc >= seg_len) begin
          adv_ticks = '0;
          if (seg_idx_r >= 3'd5) begin
            end_per = 1'b1;
          end else begin
            adv_idx = seg_idx_r + 3'd1;
          end
        end else begin
          adv_ticks = tick_inc;
        end
      end
      WAVE_TRI: begin
        direct_lvl = ramp_r[7:0];
        if (!fall_r) begin
          if (ramp_r >= TRI_TOP - 9'd1) begin
            adv_ramp = TRI_TOP;
            adv_fall = 1'b1;
          end else begin
            adv_ramp = ramp_r + 9'd1;
          end
        end else if (ramp_r == 9'd0) begin
          end_per = 1'b1;
        end else begin
          adv_ramp = ramp_r - 9'd1;
        end
      end
      WAVE_SINE: begin
        if (!fall_r) begin
          if (ramp_r < {1'b0, act_amp_r}) begin
            direct_lvl = ramp_r[7:0];
            if (sine_up >= {1'b0, act_amp_r}) begin
              adv_ramp = {1'b0, act_amp_r};
              adv_fall = 1'b1;
            end else begin
              adv_ramp = sine_up;
            end
          end else begin
            end_per = 1'b1;
          end
        end else begin
          direct_lvl = ramp_r[7:0];
          if (ramp_r <= RAMP_STEP) begin
            end_per = 1'b1;
          end else begin
            adv_ramp = ramp_r - RAMP_STEP;
          end
        end
      end
      default: begin
        direct_lvl = LEVEL_FULL;
      end
    endcase
    if (end_per) begin
      adv_idx   = '0;
      adv_ticks = '0;
      adv_ramp  = '0;
      adv_fall  = 1'b0;
    end
  end

  // Input side is open only in idle with room in the output register.
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    pend_flag_nxt = pend_flag_r;
    pend_wave_nxt = pend_wave_r;
    pend_amp_nxt  = pend_amp_r;
    pend_per_nxt  = pend_per_r;
    act_wave_nxt  = act_wave_r;
    act_amp_nxt   = act_amp_r;
    act_per_nxt   = act_per_r;
    seg_idx_nxt   = seg_idx_r;
    seg_ticks_nxt = seg_ticks_r;
    ramp_nxt      = ramp_r;
    fall_nxt      = fall_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_level_nxt = out_level_r;
    frame_we      = 1'b0;
    div_req       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          op_nxt    = in_opcode;
          byte_nxt  = in_rx_byte;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == OP_BYTE) begin
          frame_we  = 1'b1;
          state_nxt = ST_IDLE;
          if (evt.last && evt.ok) begin
            pend_wave_nxt = evt.wave;
            pend_amp_nxt  = evt.amp;
            if (evt.freq < FREQ_MIN) begin
              pend_per_nxt  = PERIOD_SAT;
              pend_flag_nxt = 1'b1;
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_FRAME_OK;
              out_level_nxt = '0;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = PERIOD_NUM;
              div_req.divisor  = evt.freq;
              state_nxt        = ST_PDIV;
            end
          end else if (evt.last) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_FRAME_BAD;
            out_level_nxt = '0;
          end
        end else begin
          // Pending settings take over only on a period boundary.
          if (at_start && pend_flag_r) begin
            act_wave_nxt  = pend_wave_r;
            act_amp_nxt   = pend_amp_r;
            act_per_nxt   = pend_per_r;
            pend_flag_nxt = 1'b0;
          end
          state_nxt = ST_TICK;
        end
      end
      ST_TICK: begin
        if (wave_ok) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SAMPLE;
          out_level_nxt = direct_lvl;
          seg_idx_nxt   = adv_idx;
          seg_ticks_nxt = adv_ticks;
          ramp_nxt      = adv_ramp;
          fall_nxt      = adv_fall;
        end
        state_nxt = ST_IDLE;
      end
      ST_PDIV: begin
        if (div_rsp.done) begin
          pend_per_nxt  = div_rsp.quotient[7:0];
          pend_flag_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FRAME_OK;
          out_level_nxt = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_flag_r <= 1'b0;
      pend_wave_r <= WAVE_NONE;
      pend_amp_r  <= '0;
      pend_per_r  <= PERIOD_SAT;
      act_wave_r  <= WAVE_NONE;
      act_amp_r   <= '0;
      act_per_r   <= PERIOD_SAT;
      seg_idx_r   <= '0;
      seg_ticks_r <= '0;
      ramp_r      <= '0;
      fall_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_flag_r <= pend_flag_nxt;
      pend_wave_r <= pend_wave_nxt;
      pend_amp_r  <= pend_amp_nxt;
      pend_per_r  <= pend_per_nxt;
      act_wave_r  <= act_wave_nxt;
      act_amp_r   <= act_amp_nxt;
      act_per_r   <= act_per_nxt;
      seg_idx_r   <= seg_idx_nxt;
      seg_ticks_r <= seg_ticks_nxt;
      ramp_r      <= ramp_nxt;
      fall_r      <= fall_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    byte_r      <= byte_nxt;
    out_kind_r  <= out_kind_nxt;
    out_level_r <= out_level_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_level = out_level_r;

endmodule

[design/scwg_checker.sv]
// ----------------------------------------------------------------------------
// scwg_checker
// Port-level checks on the wave generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_commanded_wave_generator_assert.svh"

module scwg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_level
);
  import scwg_pkg::*;

  // Stalled result holds.
  `SCWG_CHECK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_level), "stalled result changed")

  // Only the three defined kinds leave the block.
  `SCWG_CHECK(a_kind_legal, clk, rst_n, out_valid |-> out_kind == KIND_SAMPLE || out_kind == KIND_FRAME_OK || out_kind == KIND_FRAME_BAD, "undefined result kind")

  // Frame status carries a zero level.
  `SCWG_CHECK(a_status_level, clk, rst_n, out_valid && out_kind != KIND_SAMPLE |-> out_level == 8'd0, "nonzero level on frame status")

  // One item at a time: busy right after a transfer.
  `SCWG_CHECK(a_busy_after_take, clk, rst_n, in_valid && !in_stall |=> in_stall, "second item taken while busy")

  // Reset empties the output register.
  `SCWG_CHECK_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result present after reset")

endmodule

bind serial_commanded_wave_generator scwg_checker u_scwg_checker (.*);

[bench/serial_commanded_wave_generator_tb.sv]
// ----------------------------------------------------------------------------
// serial_commanded_wave_generator_tb
// Self-checking bench: streams command frames, noise and sample ticks into
// the generator, predicts every DAC sample and frame verdict, and compares
// each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_commanded_wave_generator_tb;

  import scwg_pkg::*;

  localparam int unsigned IDLE_PCT    = 16;        // chance in percent of a bubble or a stall per cycle
  localparam int unsigned HOLD_CYCLES = 300;       // long receiver back-pressure
  localparam int unsigned TOTAL_ITEMS = 1550;
  localparam int unsigned TAIL_CYCLES = 40;        // room for any stray late transfer
  localparam int unsigned TIMEOUT_NS  = 5_000_000;
  localparam int unsigned MAX_SHOWN   = 10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] level;
  } dac_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the generator state, advanced on every input
  // transfer; predicted transfers wait in awaited_results in order.
  // --------------------------------------------------------------------------
  class wave_scoreboard;
    int unsigned  byte_count;
    logic [7:0]   frame_bytes [8];
    bit           queued_valid;
    logic [7:0]   queued_wave, queued_amp, queued_period;
    logic [7:0]   live_wave, live_amp, live_period;
    int unsigned  seg_index, seg_ticks, ramp;
    bit           ramp_down;
    dac_result_t  awaited_results [$];
    int unsigned  mismatches;

    function new();
      byte_count    = 0;
      foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
      queued_valid  = 1'b0;
      queued_wave   = WAVE_NONE;
      queued_amp    = 8'd0;
      queued_period = PERIOD_SAT;
      live_wave     = WAVE_NONE;
      live_amp      = 8'd0;
      live_period   = PERIOD_SAT;
      mismatches    = 0;
      finish_period();
    endfunction

    function void finish_period();
      seg_index = 0;
      seg_ticks = 0;
      ramp      = 0;
      ramp_down = 1'b0;
    endfunction

    // Leading decimal digits of a three-char field, kept mod 256
    function logic [7:0] digits_value(logic [7:0] c2, logic [7:0] c1, logic [7:0] c0);
      logic [7:0]  chars [3];
      int unsigned value;
      chars = '{c2, c1, c0};
      value = 0;
      foreach (chars[k]) begin
        if (chars[k] < CH_0 || chars[k] > CH_9) break;
        value = value * 10 + (chars[k] - CH_0);
      end
      return value[7:0];
    endfunction

    function logic [7:0] period_for(logic [7:0] freq);
      int unsigned quotient;
      if (freq < FREQ_MIN) return PERIOD_SAT;
      quotient = PERIOD_NUM / freq;
      return quotient[7:0];
    endfunction

    // Counts one tick of a timed segment; zero-length segments last one tick
    function bit seg_step(int unsigned len);
      if (len == 0) len = 1;
      seg_ticks++;
      if (seg_ticks >= len) begin
        seg_ticks = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void predict_tick();
      int unsigned a, p, lvl;
      dac_result_t res;
      // pending settings only take over on a period boundary
      if (seg_index == 0 && seg_ticks == 0 && ramp == 0 && !ramp_down && queued_valid) begin
        live_wave    = queued_wave;
        live_amp     = queued_amp;
        live_period  = queued_period;
        queued_valid = 1'b0;
      end
      if (live_wave >= NUM_WAVES || live_wave >= WAVE_NONE) return;
      a   = live_amp;
      p   = live_period;
      lvl = 0;
      case (live_wave)
        WAVE_SQUARE: begin
          lvl = (seg_index == 0) ? a : 0;
          if (seg_step(seg_index == 0 ? 2 * p : p / 2)) begin
            seg_index++;
            if (seg_index >= 2) finish_period();
          end
        end
        WAVE_STAIR: begin
          case (seg_index)
            0:       lvl = 0;
            1:       lvl = (a * 4) / 5;
            2:       lvl = (a * 3) / 5;
            3:       lvl = (a * 2) / 5;
            4:       lvl = a / 5;
            default: lvl = a;
          endcase
          if (seg_step(p)) begin
            seg_index++;
            if (seg_index >= 6) finish_period();
          end
        end
        WAVE_TRI: begin
          lvl = ramp;
          if (!ramp_down) begin
            ramp++;
            if (ramp >= TRI_TOP) begin
              ramp      = TRI_TOP;
              ramp_down = 1'b1;
            end
          end else if (ramp == 0) begin
            finish_period();
          end else begin
            ramp--;
          end
        end
        WAVE_SINE: begin
          if (!ramp_down) begin
            if (ramp < a) begin
              lvl  = ramp;
              ramp = ramp + RAMP_STEP;
              if (ramp >= a) begin
                ramp      = a;
                ramp_down = 1'b1;
              end
            end else begin
              lvl = 0;
              finish_period();
            end
          end else begin
            lvl = ramp;
            if (ramp <= RAMP_STEP) finish_period();
            else ramp = ramp - RAMP_STEP;
          end
        end
        default: lvl = LEVEL_FULL;
      endcase
      res.kind  = KIND_SAMPLE;
      res.level = lvl[7:0];
      awaited_results.push_back(res);
    endfunction

    function void predict_byte(logic [7:0] data);
      dac_result_t res;
      if (byte_count < FRAME_BYTES - 1) begin
        frame_bytes[byte_count] = data;
        byte_count++;
        return;
      end
      byte_count = 0;
      res.level  = 8'd0;
      if (frame_bytes[0] == CH_START && data == CH_END) begin
        queued_wave   = frame_bytes[1] - CH_0;
        queued_amp    = digits_value(frame_bytes[2], frame_bytes[3], frame_bytes[4]);
        queued_period = period_for(digits_value(frame_bytes[5], frame_bytes[6],
                                                frame_bytes[7]));
        queued_valid  = 1'b1;
        res.kind      = KIND_FRAME_OK;
      end else begin
        res.kind = KIND_FRAME_BAD;
      end
      awaited_results.push_back(res);
    endfunction

    function void note_transfer(logic opcode, logic [7:0] data);
      if (opcode == OP_TICK) predict_tick();
      else predict_byte(data);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] level);
      dac_result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: unexpected transfer kind %0d level %0d", $time, kind, level);
        return;
      end
      want = awaited_results.pop_front();
      if (kind !== want.kind || level !== want.level) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: mismatch: expected kind %0d level %0d, got kind %0d level %0d",
                   $time, want.kind, want.level, kind, level);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_opcode  = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_level;

  wave_scoreboard sb;
  int unsigned    items_sent    = 0;
  int unsigned    frame_phase   = 0;   // bytes into the current 9-byte frame
  int unsigned    hold_requests = 0;   // bumped by stimulus, served by receiver
  bit             steady        = 1'b0; // no bubbles and no stalls while set

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  serial_commanded_wave_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_level  (out_level)
  );

  // --------------------------------------------------------------------------
  // Driver tasks. All driving happens at the falling edge; acceptance is
  // judged at the rising edge from the pre-edge value of in_stall.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic opcode, input logic [7:0] data);
    // random bubbles; payload is free to wander while valid is low
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid   = 1'b0;
      in_opcode  = 1'($urandom_range(1));
      in_rx_byte = 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_opcode  = opcode;
    in_rx_byte = data;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_transfer(opcode, data);
    items_sent++;
    if (opcode == OP_BYTE) frame_phase = (frame_phase + 1) % FRAME_BYTES;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_item(OP_TICK, 8'($urandom_range(255)));
  endtask

  // Nine bytes, first byte in the top octet
  task automatic send_frame(input logic [71:0] text);
    for (int k = FRAME_BYTES - 1; k >= 0; k--) send_item(OP_BYTE, text[k*8 +: 8]);
  endtask

  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (sb.awaited_results.size() != 0) @(negedge clk);
  endtask

  // Digit char with an occasional stray byte to cut the number short
  function automatic logic [7:0] digit_char(input int unsigned digit);
    if ($urandom_range(99) < 8) return 8'($urandom_range(255));
    return CH_0 + 8'(digit);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request so the
  // output register fills and the block backs up into in_stall.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned holds_served;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Output monitor: every transfer goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
      sb.check_result(out_kind, out_level);
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned scenario, pick, amp, freq;
    logic [7:0]  wave_ch;
    logic [71:0] frame;
    bit          hold_asked, drain_paused;

    sb           = new();
    scenario     = 0;
    hold_asked   = 1'b0;
    drain_paused = 1'b0;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed part.
    // No wave selected after reset: a tick gives nothing back.
    send_item(OP_TICK, 8'hFF);
    // Sine, amplitude cut short by a letter (0), frequency zero -> saturated
    // period; a flat sine period is a single zero sample.
    send_frame("@30AB000;");
    send_item(OP_TICK, 8'h00);
    // Bad start byte with '@' further in: no resync, whole frame rejected.
    // Covers rx_byte 00 and FF.
    send_frame({8'h00, CH_START, {6{8'hFF}}, CH_END});
    send_item(OP_TICK, 8'hFF);
    wait_for_drain();

    // Random part: frames (mostly well formed), noise and bursts of ticks.
    while (items_sent < TOTAL_ITEMS) begin
      if (!hold_asked && items_sent >= 500) begin
        hold_requests++;
        hold_asked = 1'b1;
      end
      if (!drain_paused && items_sent >= 1100) begin
        wait_for_drain();
        drain_paused = 1'b1;
      end
      steady = (items_sent >= 650 && items_sent < 950);

      pick = $urandom_range(99);
      if (pick < 10) begin
        // stray bytes; these shift the frame alignment
        repeat ($urandom_range(1, 6)) send_item(OP_BYTE, 8'($urandom_range(255)));
      end else begin
        // pad out any partial frame first
        while (frame_phase != 0) send_item(OP_BYTE, 8'($urandom_range(255)));

        pick = $urandom_range(99);
        if (scenario == 2) wave_ch = CH_0 + WAVE_TRI;
        else if (pick < 85) wave_ch = CH_0 + 8'($urandom_range(4));
        else if (pick < 95) wave_ch = CH_0 + 8'($urandom_range(5, 9));
        else wave_ch = 8'($urandom_range(255));

        amp  = $urandom_range(999);
        pick = $urandom_range(99);
        if (pick < 60) freq = $urandom_range(60, 255);       // short periods
        else if (pick < 80) freq = $urandom_range(4, 59);
        else if (pick < 90) freq = $urandom_range(3);        // saturated period
        else freq = $urandom_range(255);
        // exercise the mod-256 wrap of three-digit values
        if ($urandom_range(99) < 30 && freq + 256 <= 999)
          freq += 256 * $urandom_range(1, (999 - freq) / 256);

        frame = {CH_START, wave_ch,
                 digit_char(amp / 100), digit_char(amp / 10 % 10), digit_char(amp % 10),
                 digit_char(freq / 100), digit_char(freq / 10 % 10), digit_char(freq % 10),
                 CH_END};
        // broken frame: corrupt the start or the end marker
        if (scenario != 2 && $urandom_range(99) < 15) begin
          if ($urandom_range(1)) frame[71:64] = CH_START ^ 8'($urandom_range(1, 255));
          else frame[7:0] = CH_END ^ 8'($urandom_range(1, 255));
        end
        send_frame(frame);
      end

      // tick burst; one long one runs a whole triangle period
      pick = $urandom_range(99);
      if (scenario == 2) send_ticks(520);
      else if (pick < 75) send_ticks($urandom_range(30));
      else if (pick < 95) send_ticks($urandom_range(31, 120));
      else send_ticks($urandom_range(200, 300));
      scenario++;
    end
    steady = 1'b0;

    // Drain, then leave room for any stray late transfer to show up
    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[serial_commanded_wave_generator.f]
+incdir+design
design/scwg_pkg.sv
design/scwg_div.sv
design/scwg_frame.sv
design/serial_commanded_wave_generator.sv
design/scwg_checker.sv
bench/serial_commanded_wave_generator_tb.sv
